>>> rtl/core/tqs_pkg.sv
// Package with the shared types, constants and codes of the thread queue scheduler.
package tqs_pkg;

   localparam int POOL_THREADS = 4;
   localparam int MUTEX_COUNT  = 8;
   localparam int LINKS        = POOL_THREADS + 1;
   localparam int MUTEX_INDEX_W = 3;
   localparam int MUTEX_SLOTS  = (MUTEX_COUNT < (1 << MUTEX_INDEX_W)) ?
                                 MUTEX_COUNT : (1 << MUTEX_INDEX_W);
   localparam int TICK_W       = 16;

   typedef logic [2:0] ptr_type;

   localparam ptr_type NIL     = 3'd7;
   localparam ptr_type MAIN_ID = ptr_type'(POOL_THREADS);

   typedef enum logic [2:0] {
      OP_SPAWN  = 3'd0,
      OP_YIELD  = 3'd1,
      OP_TICK   = 3'd2,
      OP_LOCK   = 3'd3,
      OP_UNLOCK = 3'd4,
      OP_EXIT   = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_FREE   = 3'd1,
      ST_NO_READY  = 3'd2,
      ST_HALTED    = 3'd3,
      ST_MAIN_EXIT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_FIRST,
      FSM_SECOND,
      FSM_FINISH
   } fsm_type;

   typedef enum logic [1:0] {
      Q_FREE,
      Q_READY,
      Q_WAIT
   } qsel_type;

   typedef struct packed {
      logic    valid;
      logic    pop;
      ptr_type head;
      ptr_type tail;
      ptr_type item;
   } list_cmd_type;

   typedef struct packed {
      ptr_type head;
      ptr_type tail;
      ptr_type popped;
   } list_res_type;

endpackage

>>> rtl/core/tqs_if.sv
// Channel interfaces for scheduler events and scheduler results.
interface tqs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [2:0] mutex_index;

   modport source (output valid, output op, output mutex_index, input ready);
   modport sink (input valid, input op, input mutex_index, output ready);
endinterface

interface tqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  running_thread;
   logic [1:0]  new_thread;
   logic [2:0]  status;
   logic [15:0] tick_value;
   logic        switched;

   modport source (output valid, output running_thread, output new_thread, output status,
                   output tick_value, output switched, input ready);
   modport sink (input valid, input running_thread, input new_thread, input status,
                 input tick_value, input switched, output ready);
endinterface

>>> rtl/core/thread_queue_scheduler.sv
// Top level of the thread queue scheduler with event and result channels.
//
//   channel  dir  handshake     beat contents
//   req      in   valid/ready   op, mutex_index
//   rsp      out  valid/ready   running_thread, new_thread, status, tick_value, switched
//
// An event is accepted only while the sequencer is idle, so a new event waits until the
// result of the last one is loaded. Each event passes the accepting cycle, a decision
// cycle, an optional second list step, and a finish step that loads the result.
// The shared list unit performs one push or pop per cycle.
// A full result register holds the sequencer in its last step until the beat is taken.
// Synchronous active-high reset restores the free list, empty queues and the main thread.
module thread_queue_scheduler
   import tqs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tqs_req_if.sink   req,
   tqs_rsp_if.source rsp
);

   list_cmd_type list_cmd;
   list_res_type list_res;

   tqs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .cmd   (list_cmd),
      .res   (list_res)
   );

   tqs_list_unit u_list (
      .clock (clock),
      .reset (reset),
      .cmd   (list_cmd),
      .res   (list_res)
   );

endmodule

>>> rtl/core/tqs_list_unit.sv
// Shared linked-list unit: one push or pop per cycle on the link table.
module tqs_list_unit
   import tqs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  list_cmd_type cmd,
   output list_res_type res
);

   ptr_type link_ff [LINKS];
   ptr_type rd_next;
   logic    push_ok;
   logic    head_ok;
   logic    tail_ok;
   logic    wr_item;
   logic    wr_tail;

   always_comb begin
      rd_next = NIL;
      for (int i = 0; i < LINKS; i++) begin
         if (cmd.head == ptr_type'(i)) begin
            rd_next = link_ff[i];
         end
      end
      push_ok = int'(cmd.item) < LINKS;
      head_ok = int'(cmd.head) < LINKS;
      tail_ok = int'(cmd.tail) < LINKS;
      res.head   = cmd.head;
      res.tail   = cmd.tail;
      res.popped = NIL;
      wr_item = 1'b0;
      wr_tail = 1'b0;
      if (cmd.pop) begin
         if (!head_ok) begin
            res.head = NIL;
            res.tail = NIL;
         end else begin
            res.popped = cmd.head;
            res.head   = rd_next;
            if (rd_next == NIL) begin
               res.tail = NIL;
            end
         end
      end else if (push_ok) begin
         wr_item  = cmd.valid;
         res.tail = cmd.item;
         if (cmd.head == NIL || !tail_ok) begin
            res.head = cmd.item;
         end else begin
            wr_tail = cmd.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINKS; i++) begin
            link_ff[i] <= (i + 1 < POOL_THREADS) ? ptr_type'(i + 1) : NIL;
         end
      end else begin
         for (int i = 0; i < LINKS; i++) begin
            if (wr_tail && cmd.tail == ptr_type'(i)) begin
               link_ff[i] <= cmd.item;
            end else if (wr_item && cmd.item == ptr_type'(i)) begin
               link_ff[i] <= NIL;
            end
         end
      end
   end

endmodule

>>> rtl/core/tqs_ctrl.sv
// Event sequencer holding queue pointers, mutex state, tick count and the result register.
module tqs_ctrl
   import tqs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   tqs_req_if.sink       req,
   tqs_rsp_if.source     rsp,
   output list_cmd_type  cmd,
   input  list_res_type  res
);

   fsm_type    state_ff, state_in;
   logic [2:0] op_ff;
   logic [MUTEX_INDEX_W-1:0] m_ff;
   ptr_type    before_ff;
   ptr_type    item_ff;
   logic [1:0] spawned_ff;
   status_type status_ff;

   ptr_type    free_head_ff, free_tail_ff;
   ptr_type    ready_head_ff, ready_tail_ff;
   ptr_type    wait_head_ff [MUTEX_SLOTS];
   ptr_type    wait_tail_ff [MUTEX_SLOTS];
   logic       locked_ff [MUTEX_SLOTS];
   ptr_type    current_ff;
   logic [TICK_W-1:0] tick_ff;
   logic       halted_ff;

   logic       rsp_valid_ff;
   ptr_type    rsp_running_ff;
   logic [1:0] rsp_new_ff;
   status_type rsp_status_ff;
   logic [TICK_W-1:0] rsp_tick_ff;
   logic       rsp_switched_ff;

   logic       accept;
   logic       m_ok;
   ptr_type    sel_wait_head;
   ptr_type    sel_wait_tail;
   logic       sel_locked;
   logic       out_free;

   logic       go_second;
   status_type first_status;
   logic       set_halt;
   logic       lock_set;
   logic       lock_clear;
   logic       tick_inc;
   logic       tick_clr;
   logic       first_valid;
   logic       first_pop;
   qsel_type   first_qsel;
   ptr_type    first_item;

   logic       step_valid;
   logic       step_pop;
   qsel_type   step_qsel;
   ptr_type    step_item;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign m_ok     = int'(m_ff) < MUTEX_COUNT;

   always_comb begin
      sel_wait_head = NIL;
      sel_wait_tail = NIL;
      sel_locked    = 1'b0;
      for (int i = 0; i < MUTEX_SLOTS; i++) begin
         if (int'(m_ff) == i) begin
            sel_wait_head = wait_head_ff[i];
            sel_wait_tail = wait_tail_ff[i];
            sel_locked    = locked_ff[i];
         end
      end
   end

   always_comb begin
      go_second    = 1'b0;
      first_status = ST_OK;
      set_halt     = 1'b0;
      lock_set     = 1'b0;
      lock_clear   = 1'b0;
      tick_inc     = 1'b0;
      tick_clr     = 1'b0;
      first_valid  = 1'b0;
      first_pop    = 1'b0;
      first_qsel   = Q_READY;
      first_item   = current_ff;
      if (halted_ff) begin
         first_status = ST_HALTED;
      end else begin
         case (op_ff) inside
            OP_SPAWN: begin
               if (free_head_ff == NIL) begin
                  set_halt     = 1'b1;
                  first_status = ST_NO_FREE;
               end else begin
                  first_valid = 1'b1;
                  first_pop   = 1'b1;
                  first_qsel  = Q_FREE;
                  go_second   = 1'b1;
               end
            end
            OP_YIELD, OP_TICK: begin
               tick_inc    = (op_ff == OP_TICK);
               first_valid = 1'b1;
               go_second   = 1'b1;
            end
            OP_LOCK: begin
               if (m_ok) begin
                  if (!sel_locked) begin
                     lock_set = 1'b1;
                  end else if (ready_head_ff == NIL) begin
                     set_halt     = 1'b1;
                     first_status = ST_NO_READY;
                  end else begin
                     first_valid = 1'b1;
                     first_qsel  = Q_WAIT;
                     go_second   = 1'b1;
                  end
               end
            end
            OP_UNLOCK: begin
               if (m_ok) begin
                  if (sel_wait_head != NIL) begin
                     first_valid = 1'b1;
                     first_pop   = 1'b1;
                     first_qsel  = Q_WAIT;
                     go_second   = 1'b1;
                  end else begin
                     lock_clear = 1'b1;
                  end
               end
            end
            OP_EXIT: begin
               if (current_ff == MAIN_ID) begin
                  first_status = ST_MAIN_EXIT;
               end else if (ready_head_ff == NIL) begin
                  set_halt     = 1'b1;
                  first_status = ST_NO_READY;
               end else begin
                  first_valid = 1'b1;
                  first_qsel  = Q_FREE;
                  go_second   = 1'b1;
               end
            end
            OP_CLEAR: begin
               tick_clr = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:   if (accept) state_in = FSM_FIRST;
         FSM_FIRST:  state_in = go_second ? FSM_SECOND : FSM_FINISH;
         FSM_SECOND: state_in = FSM_FINISH;
         FSM_FINISH: if (out_free) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req.ready  = 1'b0;
      step_valid = 1'b0;
      step_pop   = 1'b0;
      step_qsel  = Q_READY;
      step_item  = current_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            req.ready = 1'b1;
         end
         FSM_FIRST: begin
            step_valid = first_valid;
            step_pop   = first_pop;
            step_qsel  = first_qsel;
            step_item  = first_item;
         end
         FSM_SECOND: begin
            step_valid = 1'b1;
            step_pop   = !(op_ff == OP_SPAWN || op_ff == OP_UNLOCK);
            step_item  = item_ff;
         end
         FSM_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cmd.valid = step_valid;
      cmd.pop   = step_pop;
      cmd.item  = step_item;
      case (step_qsel)
         Q_FREE: begin
            cmd.head = free_head_ff;
            cmd.tail = free_tail_ff;
         end
         Q_WAIT: begin
            cmd.head = sel_wait_head;
            cmd.tail = sel_wait_tail;
         end
         default: begin
            cmd.head = ready_head_ff;
            cmd.tail = ready_tail_ff;
         end
      endcase
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.running_thread = rsp_running_ff;
   assign rsp.new_thread     = rsp_new_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.tick_value     = rsp_tick_ff;
   assign rsp.switched       = rsp_switched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         free_head_ff  <= '0;
         free_tail_ff  <= ptr_type'(POOL_THREADS - 1);
         ready_head_ff <= NIL;
         ready_tail_ff <= NIL;
         for (int i = 0; i < MUTEX_SLOTS; i++) begin
            wait_head_ff[i] <= NIL;
            wait_tail_ff[i] <= NIL;
            locked_ff[i]    <= 1'b0;
         end
         current_ff   <= MAIN_ID;
         tick_ff      <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (step_valid) begin
            case (step_qsel)
               Q_FREE: begin
                  free_head_ff <= res.head;
                  free_tail_ff <= res.tail;
               end
               Q_WAIT: begin
                  for (int i = 0; i < MUTEX_SLOTS; i++) begin
                     if (int'(m_ff) == i) begin
                        wait_head_ff[i] <= res.head;
                        wait_tail_ff[i] <= res.tail;
                     end
                  end
               end
               default: begin
                  ready_head_ff <= res.head;
                  ready_tail_ff <= res.tail;
               end
            endcase
         end
         if (state_ff == FSM_FIRST) begin
            if (set_halt) begin
               halted_ff <= 1'b1;
            end
            for (int i = 0; i < MUTEX_SLOTS; i++) begin
               if (int'(m_ff) == i) begin
                  if (lock_set) begin
                     locked_ff[i] <= 1'b1;
                  end else if (lock_clear) begin
                     locked_ff[i] <= 1'b0;
                  end
               end
            end
            if (tick_inc) begin
               tick_ff <= tick_ff + 1'b1;
            end else if (tick_clr) begin
               tick_ff <= '0;
            end
         end
         if (state_ff == FSM_SECOND && step_pop) begin
            current_ff <= res.popped;
         end
         if (state_ff == FSM_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req.op;
         m_ff       <= req.mutex_index;
         before_ff  <= current_ff;
         spawned_ff <= '0;
      end
      if (state_ff == FSM_FIRST) begin
         status_ff <= first_status;
         if (step_valid && step_pop) begin
            item_ff <= res.popped;
            if (op_ff == OP_SPAWN) begin
               spawned_ff <= res.popped[1:0];
            end
         end
      end
      if (state_ff == FSM_FINISH && out_free) begin
         rsp_running_ff  <= current_ff;
         rsp_new_ff      <= spawned_ff;
         rsp_status_ff   <= status_ff;
         rsp_tick_ff     <= tick_ff;
         rsp_switched_ff <= (current_ff != before_ff);
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_FINISH))
      else $error("Result beat appeared without a finished event.");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("Halt flag cleared without reset.");

   a_current_valid: assert property (@(posedge clock) disable iff (reset)
      int'(current_ff) < LINKS)
      else $error("Running thread is not a slot or the main thread.");

   a_ready_ends: assert property (@(posedge clock) disable iff (reset)
      (ready_head_ff == NIL) == (ready_tail_ff == NIL))
      else $error("Ready queue head and tail disagree on emptiness.");

   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_SECOND |-> $past(state_ff == FSM_FIRST))
      else $error("Second list step without a first step.");
`endif

endmodule
